// File: hdl/frame_context_splicer_assert.svh
// Assertion macros used by the splicer sequencer.
`ifndef FRAME_CONTEXT_SPLICER_ASSERT_SVH
`define FRAME_CONTEXT_SPLICER_ASSERT_SVH

// Clocked check, masked while reset is held.
`define FCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define FCS_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/fcs_pkg.sv
// Shared types, constants and register codes of the frame context splicer.
package fcs_pkg;

    localparam int MAX_HALF_WIDTH_DEF = 15;
    localparam int MAX_FEAT_DEF       = 64;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEAT_SIZE    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECIM_PERIOD = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_ROWS   = 4'd3;

    localparam logic [3:0]  RST_HALF_WIDTH   = 4'd5;
    localparam logic [6:0]  RST_FEAT_SIZE    = 7'd40;
    localparam logic [7:0]  RST_DECIM_PERIOD = 8'd0;
    localparam logic [10:0] RST_BATCH_ROWS   = 11'd16;

    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic [31:0] value_res;
        logic        row_last;
        logic        batch_last;
        logic        stream_done;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_LD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd;
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic done;
        logic fin;
        logic busy;
    } t_stat;

endpackage

// File: hdl/fcs_chan_if.sv
// Valid/ready channel carrying one payload beat.
interface fcs_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/frame_context_splicer.sv
// Top level of the frame context splicer.
//
//  channel     dir  payload                                        beat when
//  i_in_chan   in   req_type, value                                valid && ready
//  o_out_chan  out  value_res, row_last, batch_last, stream_done   valid && ready
//  i_cfg_*     in   index, data                                    i_cfg_we
//
// A kept window column is accepted, then each of its 2W+1 context words is read
// from RAM, loaded and presented, with W context frames per side.
// A word with no output is only accepted; the drain-ending beat is accepted, then presented.
// A decimation period write recomputes the window residue bit by bit, input held.
// Reset is synchronous, active low; the frame RAM is not cleared.
// Output stalls hold the sequencer in its present state; input is not taken.
module frame_context_splicer #(
    parameter int MAX_HALF_WIDTH = fcs_pkg::MAX_HALF_WIDTH_DEF,
    parameter int MAX_FEAT       = fcs_pkg::MAX_FEAT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fcs_chan_if.sink                       i_in_chan,
    fcs_chan_if.source                     o_out_chan,
    input  logic                           i_cfg_we,
    input  logic [fcs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fcs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    fcs_pkg::t_cmd  cmd;
    fcs_pkg::t_stat stat;
    fcs_pkg::t_in   in_data;
    fcs_pkg::t_out  out_data;

    assign in_data         = i_in_chan.data;
    assign o_out_chan.data = out_data;

    fcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_chan.valid),
        .o_in_ready  (i_in_chan.ready),
        .o_out_valid (o_out_chan.valid),
        .i_out_ready (o_out_chan.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fcs_dp #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .MAX_FEAT       (MAX_FEAT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in       (in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_out      (out_data)
    );
endmodule

// File: hdl/fcs_ram.sv
// Generic simple dual-port RAM with registered read.
module fcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1984
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/fcs_ctrl.sv
// Sequencer: accepts an item, then reads and presents each context word, or presents the drain-ending beat directly.
`include "frame_context_splicer_assert.svh"
module fcs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  fcs_pkg::t_stat i_stat,
    output fcs_pkg::t_cmd  o_cmd
);
    fcs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            fcs_pkg::S_IDLE: begin
                o_in_ready = !i_stat.busy;
                if (i_in_valid && !i_stat.busy) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.emit) begin
                        n_state = fcs_pkg::S_RD;
                    end else if (i_stat.done) begin
                        n_state = fcs_pkg::S_OUT;
                    end
                end
            end
            fcs_pkg::S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = fcs_pkg::S_LD;
            end
            fcs_pkg::S_LD: begin
                o_cmd.load = 1'b1;
                n_state    = fcs_pkg::S_OUT;
            end
            fcs_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.fin) begin
                        n_state = fcs_pkg::S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = fcs_pkg::S_RD;
                    end
                end
            end
            default: n_state = fcs_pkg::S_IDLE;
        endcase
    end

    `FCS_ASSERT(a_rd_then_ld, (r_state == fcs_pkg::S_RD) |=> (r_state == fcs_pkg::S_LD), "read not followed by load")
    `FCS_ASSERT(a_done_direct, (o_cmd.accept && !i_stat.emit && i_stat.done) |=> (r_state == fcs_pkg::S_OUT), "done beat not presented")
    `FCS_ASSERT(a_fin_idle, (o_out_valid && i_out_ready && i_stat.fin) |=> (r_state == fcs_pkg::S_IDLE), "window end did not return to idle")
    `FCS_ASSERT_NR(a_reset_idle, (!i_rst_n) |=> (r_state == fcs_pkg::S_IDLE), "reset did not idle sequencer")
endmodule

// File: hdl/fcs_dp.sv
// Datapath: ring bookkeeping, window counters, frame RAM and output register.
module fcs_dp #(
    parameter int MAX_HALF_WIDTH = fcs_pkg::MAX_HALF_WIDTH_DEF,
    parameter int MAX_FEAT       = fcs_pkg::MAX_FEAT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fcs_pkg::t_cmd                     i_cmd,
    input  fcs_pkg::t_in                      i_in,
    input  logic                              i_cfg_we,
    input  logic [fcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fcs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output fcs_pkg::t_stat                    o_stat,
    output fcs_pkg::t_out                     o_out
);
    localparam int SLOTS = 2 * MAX_HALF_WIDTH + 1;
    localparam int SW    = $clog2(SLOTS + 1);
    localparam int FW    = MAX_FEAT > 1 ? $clog2(MAX_FEAT) : 1;
    localparam int FCW   = $clog2(MAX_FEAT + 1);
    localparam int DEPTH = SLOTS * MAX_FEAT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    // configuration
    logic [3:0]  r_half;
    logic [6:0]  r_feat;
    logic [7:0]  r_skip;
    logic [10:0] r_rows;

    // stream state
    logic [SW-1:0] r_ro, r_ru, r_dc, r_cp, r_slot;
    logic [FW-1:0] r_fp, r_col;
    logic          r_dr;
    logic [31:0]   r_wc;
    logic [7:0]    r_res;
    logic [10:0]   r_bf;
    logic          r_last, r_bl, r_done;

    // residue recompute
    logic          r_busy;
    logic [4:0]    r_mcnt;
    logic [31:0]   r_msh;
    logic [7:0]    r_mrem;

    fcs_pkg::t_out r_out;

    logic [SW-1:0]  w_eff, nslot;
    logic [FCW-1:0] feff;
    logic [10:0]    rows;
    logic           is_data, is_drain, ec, last, keep, done;
    logic [SW-1:0]  ru1, ro1, dc0, cp, n_dc;
    logic [SW:0]    wsum, wslot;
    logic [31:0]    wval, n_wc;
    logic [7:0]     n_res;
    logic [8:0]     res_inc;
    logic [10:0]    bf_inc, n_bf;
    logic           bl;
    logic [FW-1:0]  fp_next;
    logic [SW:0]    tt, idx0, rslot_s;
    logic [SW-1:0]  idx;
    logic [AW-1:0]  waddr, raddr;
    logic [31:0]    rdata;
    logic [8:0]     mrem9;
    logic [7:0]     mrem_n;

    always_comb begin
        w_eff = (32'(r_half) > MAX_HALF_WIDTH) ? SW'(MAX_HALF_WIDTH) : SW'(r_half);
        nslot = SW'({w_eff, 1'b1});
        if (r_feat == 7'd0) begin
            feff = FCW'(1);
        end else if (32'(r_feat) > MAX_FEAT) begin
            feff = FCW'(MAX_FEAT);
        end else begin
            feff = FCW'(r_feat);
        end
        rows = (r_rows == 11'd0) ? 11'd1 : r_rows;
    end

    // item evaluation, applied on accept
    always_comb begin
        is_data  = (i_in.req_type == fcs_pkg::REQ_DATA) ? !r_dr : (!r_dr && r_fp != '0);
        is_drain = (i_in.req_type == fcs_pkg::REQ_DRAIN) && (r_dr || r_fp == '0);
        wval     = (i_in.req_type == fcs_pkg::REQ_DATA) ? i_in.value : 32'd0;

        ru1 = r_ru;
        ro1 = r_ro;
        if (r_fp == '0) begin
            if (r_ru < nslot) begin
                ru1 = r_ru + 1'b1;
            end else begin
                ro1 = (r_ro + 1'b1 == nslot) ? '0 : r_ro + 1'b1;
            end
        end
        wsum  = {1'b0, ro1} + {1'b0, ru1} - 1'b1;
        wslot = (wsum >= {1'b0, nslot}) ? wsum - {1'b0, nslot} : wsum;
        waddr = AW'(32'(wslot) * MAX_FEAT + 32'(r_fp));

        dc0 = r_dr ? r_dc : ((r_ru > w_eff) ? r_ru - w_eff : '0);

        ec   = 1'b0;
        cp   = '0;
        done = 1'b0;
        if (is_data) begin
            ec = ru1 > w_eff;
            cp = ru1 - 1'b1 - w_eff;
        end else if (is_drain) begin
            ec   = dc0 < r_ru;
            cp   = dc0;
            done = !ec;
        end

        last    = ({1'b0, (FCW)'(r_fp)} + 1'b1) >= {1'b0, feff};
        fp_next = last ? '0 : r_fp + 1'b1;

        n_wc    = r_wc;
        n_res   = r_res;
        res_inc = {1'b0, r_res} + 1'b1;
        if (ec && r_fp == '0) begin
            n_wc  = r_wc + 1'b1;
            // residue of the count by skip, wrapping with the counter
            if (r_wc == '1) begin
                n_res = '0;
            end else begin
                n_res = (res_inc == {1'b0, r_skip}) ? 8'd0 : res_inc[7:0];
            end
        end
        keep = (r_skip <= 8'd1) || (n_res == 8'd1);

        bl     = 1'b0;
        n_bf   = r_bf;
        bf_inc = r_bf + 1'b1;
        if (ec && keep && last) begin
            if (bf_inc >= rows) begin
                bl   = 1'b1;
                n_bf = '0;
            end else begin
                n_bf = bf_inc;
            end
        end

        n_dc = (fp_next == '0) ? dc0 + 1'b1 : dc0;
    end

    // read address of the current context slot, clamped to held frames
    always_comb begin
        tt      = {1'b0, r_cp} + {1'b0, r_slot};
        idx0    = (tt < {1'b0, w_eff}) ? '0 : tt - {1'b0, w_eff};
        idx     = (idx0 > {1'b0, r_ru - 1'b1}) ? r_ru - 1'b1 : idx0[SW-1:0];
        rslot_s = {1'b0, r_ro} + {1'b0, idx};
        if (rslot_s >= {1'b0, nslot}) begin
            rslot_s = rslot_s - {1'b0, nslot};
        end
        raddr = AW'(32'(rslot_s) * MAX_FEAT + 32'(r_col));
    end

    always_comb begin
        mrem9  = {r_mrem, r_msh[31]};
        mrem_n = (mrem9 >= {1'b0, r_skip}) ? 8'(mrem9 - {1'b0, r_skip}) : mrem9[7:0];
    end

    fcs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && is_data),
        .i_waddr (waddr),
        .i_wdata (wval),
        .i_re    (i_cmd.rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= fcs_pkg::RST_HALF_WIDTH;
            r_feat <= fcs_pkg::RST_FEAT_SIZE;
            r_skip <= fcs_pkg::RST_DECIM_PERIOD;
            r_rows <= fcs_pkg::RST_BATCH_ROWS;
            r_ro   <= '0;
            r_ru   <= '0;
            r_fp   <= '0;
            r_dr   <= 1'b0;
            r_dc   <= '0;
            r_wc   <= '0;
            r_res  <= '0;
            r_bf   <= '0;
            r_busy <= 1'b0;
            r_slot <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fcs_pkg::REG_HALF_WIDTH, fcs_pkg::REG_FEAT_SIZE: begin
                    if (i_cfg_idx == fcs_pkg::REG_HALF_WIDTH) begin
                        r_half <= i_cfg_data[3:0];
                    end else begin
                        r_feat <= i_cfg_data[6:0];
                    end
                    r_ro <= '0;
                    r_ru <= '0;
                    r_fp <= '0;
                    r_dr <= 1'b0;
                    r_dc <= '0;
                end
                fcs_pkg::REG_DECIM_PERIOD: begin
                    // rebuild count mod skip, one bit a cycle while no config write comes
                    r_skip <= i_cfg_data[7:0];
                    r_busy <= 1'b1;
                    r_mcnt <= '0;
                    r_msh  <= r_wc;
                    r_mrem <= '0;
                end
                fcs_pkg::REG_BATCH_ROWS: r_rows <= i_cfg_data;
                default: ;
            endcase
        end else if (r_busy) begin
            r_mrem <= mrem_n;
            r_msh  <= {r_msh[30:0], 1'b0};
            r_mcnt <= r_mcnt + 1'b1;
            if (r_mcnt == 5'd31) begin
                r_busy <= 1'b0;
                r_res  <= mrem_n;
            end
        end else if (i_cmd.accept) begin
            r_slot <= '0;
            if (done) begin
                r_bf <= '0;
                r_ro <= '0;
                r_ru <= '0;
                r_fp <= '0;
                r_dr <= 1'b0;
                r_dc <= '0;
            end else if (is_data || is_drain) begin
                r_wc  <= n_wc;
                r_res <= n_res;
                r_bf  <= n_bf;
                if (is_data) begin
                    r_ru <= ru1;
                    r_ro <= ro1;
                    r_fp <= fp_next;
                end else begin
                    r_dr <= 1'b1;
                    r_fp <= fp_next;
                    r_dc <= n_dc;
                end
            end
        end else if (i_cmd.step) begin
            r_slot <= r_slot + 1'b1;
        end
    end

    // per-window context held during emission
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cp   <= cp;
            r_col  <= r_fp;
            r_last <= last;
            r_bl   <= bl;
            r_done <= done;
        end
        if (i_cmd.accept && done) begin
            r_out.value_res   <= '0;
            r_out.row_last    <= 1'b0;
            r_out.batch_last  <= (r_bf != '0);
            r_out.stream_done <= 1'b1;
        end else if (i_cmd.load) begin
            r_out.value_res   <= rdata;
            r_out.row_last    <= r_last && (r_slot == nslot - 1'b1);
            r_out.batch_last  <= r_last && r_bl && (r_slot == nslot - 1'b1);
            r_out.stream_done <= 1'b0;
        end
    end

    assign o_stat.emit = ec && keep;
    assign o_stat.done = done;
    assign o_stat.fin  = r_done || (r_slot == nslot - 1'b1);
    assign o_stat.busy = r_busy;
    assign o_out       = r_out;
endmodule

// File: test/frame_context_splicer_test.sv
// Self-checking testbench for the frame context splicer: a window predictor and a result checker.
module frame_context_splicer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fcs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_ITEMS  = 350;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [fcs_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [fcs_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    fcs_chan_if #(.T(fcs_pkg::t_in))  in_if ();
    fcs_chan_if #(.T(fcs_pkg::t_out)) out_if ();

    frame_context_splicer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_if.sink),
        .o_out_chan (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
    end

    // Splicer state mirror
    bit [31:0]   frame_mem [0:30][0:63];
    int unsigned half_w, feat_cfg, skip_cfg, rows_cfg;
    int unsigned ring_head, ring_fill, feat_pos, win_count, batch_count, drain_pos;
    bit          in_drain;
    bit          stream_ended;
    fcs_pkg::t_out window_words [$];

    int unsigned mismatches = 0;
    int unsigned beats_sent = 0;
    int unsigned burst_left = 0;
    bit          no_gaps = 1'b0;
    int unsigned cycles = 0;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int unsigned feat_eff();
        if (feat_cfg < 1) return 1;
        if (feat_cfg > 64) return 64;
        return feat_cfg;
    endfunction

    function automatic void clear_stream();
        ring_head = 0; ring_fill = 0; feat_pos = 0; in_drain = 0; drain_pos = 0;
    endfunction

    function automatic void emit_column(input int unsigned centre);
        int unsigned nslot, col, rows, slot;
        bit          last, keep, blast;
        int          idx;
        fcs_pkg::t_out w;
        nslot = 2 * half_w + 1;
        col   = feat_pos % 64;
        rows  = (rows_cfg == 0) ? 1 : rows_cfg;
        last  = (col + 1) >= feat_eff();
        blast = 1'b0;
        if (col == 0) win_count++;
        keep = (skip_cfg <= 1) || ((win_count % skip_cfg) == 1);
        if (keep && last) begin
            batch_count = (batch_count + 1) & 11'h7FF;
            if (batch_count >= rows) begin
                blast = 1'b1;
                batch_count = 0;
            end
        end
        if (keep) begin
            for (int s = 0; s < nslot; s++) begin
                idx = int'(centre) - int'(half_w) + s;
                if (idx < 0) idx = 0;
                if (ring_fill > 0 && idx > int'(ring_fill) - 1) idx = int'(ring_fill) - 1;
                slot = (ring_head + idx) % nslot;
                w.value_res   = frame_mem[slot][col];
                w.row_last    = last && (s == nslot - 1);
                w.batch_last  = w.row_last && blast;
                w.stream_done = 1'b0;
                window_words.push_back(w);
            end
        end
        feat_pos = last ? 0 : col + 1;
    endfunction

    function automatic void store_word(input bit [31:0] v);
        int unsigned nslot, col, slot;
        nslot = 2 * half_w + 1;
        col   = feat_pos % 64;
        if (col == 0) begin
            if (ring_fill < nslot) ring_fill++;
            else ring_head = (ring_head + 1) % nslot;
        end
        slot = (ring_head + ring_fill - 1) % nslot;
        frame_mem[slot][col] = v;
        if (ring_fill > half_w) emit_column(ring_fill - 1 - half_w);
        else feat_pos = ((col + 1) >= feat_eff()) ? 0 : col + 1;
    endfunction

    function automatic void splice_step(input logic req, input bit [31:0] v);
        fcs_pkg::t_out w;
        if (req == fcs_pkg::REQ_DATA) begin
            if (!in_drain) store_word(v);
            return;
        end
        if (!in_drain && feat_pos != 0) begin
            store_word(32'd0);
            return;
        end
        if (!in_drain) begin
            in_drain  = 1'b1;
            drain_pos = (ring_fill > half_w) ? ring_fill - half_w : 0;
        end
        if (drain_pos < ring_fill) begin
            emit_column(drain_pos);
            if (feat_pos == 0) drain_pos++;
            return;
        end
        w.value_res   = '0;
        w.row_last    = 1'b0;
        w.batch_last  = batch_count > 0;
        w.stream_done = 1'b1;
        window_words.push_back(w);
        batch_count  = 0;
        stream_ended = 1'b1;
        clear_stream();
    endfunction

    // Result checker and output stall pattern
    int unsigned stall_mode = 0;
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        fcs_pkg::t_out got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (window_words.size() == 0) begin
                report($sformatf("unexpected beat %h/%b%b%b", got.value_res, got.row_last,
                                 got.batch_last, got.stream_done));
            end else begin
                want = window_words.pop_front();
                if (got.value_res !== want.value_res || got.row_last !== want.row_last ||
                    got.batch_last !== want.batch_last || got.stream_done !== want.stream_done)
                    report($sformatf("got %h/%b%b%b want %h/%b%b%b", got.value_res,
                                     got.row_last, got.batch_last, got.stream_done,
                                     want.value_res, want.row_last, want.batch_last,
                                     want.stream_done));
            end
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(5, 60);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: out_if.ready <= 1'b1;
            1: out_if.ready <= 1'($urandom_range(0, 1));
            2: out_if.ready <= ($urandom_range(0, 4) == 0);
            default: out_if.ready <= cycles[0];
        endcase
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(input logic req, input logic [31:0] v);
        fcs_pkg::t_in b;
        int unsigned gap;
        b.req_type = req;
        b.value    = v;
        in_if.valid <= 1'b1;
        in_if.data  <= b;
        do @(posedge i_clk); while (!in_if.ready);
        splice_step(req, v);
        beats_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Wait for every expected beat, then let any word with no output finish.
    task automatic settle();
        in_if.valid <= 1'b0;
        while (window_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [fcs_pkg::CFG_IDX_W-1:0] idx, input int unsigned v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[fcs_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            fcs_pkg::REG_HALF_WIDTH: begin half_w = v & 4'hF; clear_stream(); end
            fcs_pkg::REG_FEAT_SIZE:  begin feat_cfg = v & 7'h7F; clear_stream(); end
            fcs_pkg::REG_DECIM_PERIOD: skip_cfg = v & 8'hFF;
            fcs_pkg::REG_BATCH_ROWS: rows_cfg = v & 11'h7FF;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic setup(input int unsigned w, input int unsigned f, input int unsigned s,
                         input int unsigned r);
        cfg_write(fcs_pkg::REG_HALF_WIDTH, w);
        cfg_write(fcs_pkg::REG_FEAT_SIZE, f);
        cfg_write(fcs_pkg::REG_DECIM_PERIOD, s);
        cfg_write(fcs_pkg::REG_BATCH_ROWS, r);
    endtask

    // Drain until the closing beat; when noisy, inject an ignored data word now and then.
    task automatic drain_stream(input bit noisy);
        stream_ended = 1'b0;
        while (!stream_ended) begin
            if (noisy && in_drain && $urandom_range(0, 7) == 0)
                send_beat(fcs_pkg::REQ_DATA, $urandom);
            else
                send_beat(fcs_pkg::REQ_DRAIN, $urandom);
        end
    endtask

    task automatic test_edges();
        // Short stream, extreme words, drain cutting a frame, data after a mid-frame drain beat.
        setup(2, 3, 0, 2);
        send_beat(fcs_pkg::REQ_DATA, 32'h0000_0000);
        send_beat(fcs_pkg::REQ_DATA, 32'hFFFF_FFFF);
        send_beat(fcs_pkg::REQ_DATA, 32'hA5A5_5A5A);
        send_beat(fcs_pkg::REQ_DATA, 32'h8000_0001);
        drain_stream(1'b0);
        send_beat(fcs_pkg::REQ_DATA, 32'h1234_5678);
        send_beat(fcs_pkg::REQ_DRAIN, 32'hFFFF_FFFF);
        send_beat(fcs_pkg::REQ_DATA, 32'hDEAD_BEEF);
        drain_stream(1'b0);
        settle();
    endtask

    task automatic test_registers();
        // Out-of-range values, unused index, skip of one, geometry change mid-frame.
        setup(0, 0, 1, 0);
        cfg_write(REG_UNUSED, 11'h7FF);
        send_beat(fcs_pkg::REQ_DATA, $urandom);
        send_beat(fcs_pkg::REQ_DATA, $urandom);
        drain_stream(1'b0);
        settle();
        setup(15, 100, 2, 2047);
        send_beat(fcs_pkg::REQ_DATA, $urandom);
        send_beat(fcs_pkg::REQ_DATA, $urandom);
        settle();
        setup(1, 2, 255, 1024);
        send_beat(fcs_pkg::REQ_DATA, $urandom);
        send_beat(fcs_pkg::REQ_DATA, $urandom);
        send_beat(fcs_pkg::REQ_DATA, $urandom);
        drain_stream(1'b0);
        settle();
    endtask

    task automatic test_random();
        int unsigned w, f, s, r, frames, start;
        start = beats_sent;
        while (beats_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: w = $urandom_range(0, 3);
                6, 7:             w = $urandom_range(4, 14);
                default:          w = 15;
            endcase
            case ($urandom_range(0, 9))
                0:       f = 64;
                1:       f = $urandom_range(0, 1) ? 0 : 127;
                default: f = $urandom_range(1, 5);
            endcase
            case ($urandom_range(0, 5))
                0, 1:    s = $urandom_range(0, 1);
                2, 3:    s = $urandom_range(2, 4);
                4:       s = 255;
                default: s = $urandom_range(0, 255);
            endcase
            r = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 5);
            no_gaps = ($urandom_range(0, 3) == 0);
            setup(w, f, s, r);
            frames = (f > 8) ? $urandom_range(1, 2) : $urandom_range(1, 10);
            for (int n = 0; n < frames * feat_eff(); n++) begin
                if ($urandom_range(0, 24) == 0) send_beat(fcs_pkg::REQ_DRAIN, $urandom);
                else send_beat(fcs_pkg::REQ_DATA, $urandom);
            end
            // Leave some streams open; the next geometry write drops them.
            if ($urandom_range(0, 5) != 0) drain_stream(1'b1);
            settle();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        half_w = fcs_pkg::RST_HALF_WIDTH; feat_cfg = fcs_pkg::RST_FEAT_SIZE;
        skip_cfg = fcs_pkg::RST_DECIM_PERIOD; rows_cfg = fcs_pkg::RST_BATCH_ROWS;
        win_count = 0; batch_count = 0;
        clear_stream();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        test_registers();
        test_random();
        settle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/fcs_pkg.sv
hdl/fcs_chan_if.sv
hdl/fcs_ram.sv
hdl/fcs_ctrl.sv
hdl/fcs_dp.sv
hdl/frame_context_splicer.sv
test/frame_context_splicer_test.sv
